// ===== sv/dlpp_pkg.sv =====
// ----------------------------------------------------------------------------
// DAG longest-path propagator package
// Shared command codes, result codes, field widths and the control and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package dlpp_pkg;

  localparam int unsigned DEF_MAX_NODES = 1024;
  localparam int unsigned DEF_MAX_LINKS = 4096;
  localparam int unsigned DEF_MAX_SLOTS = 4096;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned NODE_W   = 10;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SLOT_W   = 12;
  localparam int unsigned LINK_W   = 12;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ITEM_W   = 12;
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  // Wide enough to compare any index against any limit up to 65536.
  localparam int unsigned CMP_W = 17;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_EARLIEST = 3'd0,
    CMD_SET_LINK     = 3'd1,
    CMD_SET_SLOT     = 3'd2,
    CMD_RUN          = 3'd3,
    CMD_READ_NODE    = 3'd4,
    CMD_READ_LINK    = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUN_DONE  = 2'd0,
    ST_NODE_READ = 2'd1,
    ST_LINK_READ = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT = 2'd0,
    CFG_LINK_COUNT = 2'd1,
    CFG_SLOT_COUNT = 2'd2
  } cfg_e;

  typedef struct packed {
    logic take;
    logic run_start;
    logic node_fetch;
    logic node_init;
    logic slot_fetch;
    logic slot_skip;
    logic pred_fetch;
    logic slot_eval;
    logic node_write;
    logic out_run;
    logic out_host;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic node_active;
    logic node_last;
    logic slots_left;
    logic tgt_gt;
    logic tgt_lt;
  } dp_status_t;

endpackage

// ===== sv/dag_longest_path_propagator_top.sv =====
// ----------------------------------------------------------------------------
// DAG longest-path propagator
// Longest-path time propagation over a loaded precedence graph.
// ----------------------------------------------------------------------------
// Items arrive on the slave stream with the command in tuser. Set commands
// (earliest time, link duration, predecessor slot) give no result, so they
// can follow each other on every cycle while the output register is free.
// A node or link read passes through a host-wait state and then puts its
// result item in the output register. A run sweeps the whole node memory
// and shows one result item with status "run finished". Each node entry
// is fetched, set up and written back; a slot that matches the node being
// processed is checked, evaluated and passed; a stray slot of an earlier
// node is checked and skipped; a slot of a later node is checked and ends
// the node's walk; a final step issues the result. No new item is taken
// during a run or a read. The result waits in an output register; while
// the receiver stalls, no further item is taken. Reset clears the
// controller, the cursors and the count registers (node count one, others
// zero); the memories are left as they are and must be loaded before use.
// Count registers must be written on the plain write port only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dag_longest_path_propagator_top #(
  parameter int unsigned MAX_NODES = dlpp_pkg::DEF_MAX_NODES,
  parameter int unsigned MAX_LINKS = dlpp_pkg::DEF_MAX_LINKS,
  parameter int unsigned MAX_SLOTS = dlpp_pkg::DEF_MAX_SLOTS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dlpp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dlpp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // node_index, time_value, extra_delay, slot_index, pred_node, link number
  input  logic [dlpp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // command
  input  logic [dlpp_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // item_index, value, has_cause, cause_node
  output logic [dlpp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status
  output logic [dlpp_pkg::STATUS_W-1:0]      m_axis_tuser
);

  dlpp_pkg::ctrl_cmd_t  cmd;
  dlpp_pkg::dp_status_t status;

  logic [dlpp_pkg::ITEM_W-1:0]        out_item;
  logic signed [dlpp_pkg::TIME_W-1:0] out_value;
  logic                               out_has_cause;
  logic [dlpp_pkg::NODE_W-1:0]        out_cause;

  dlpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dlpp_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_LINKS (MAX_LINKS),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (s_axis_tvalid),
    .in_cmd_i        (s_axis_tuser),
    .in_node_i       (s_axis_tdata[9:0]),
    .in_time_i       (s_axis_tdata[41:10]),
    .in_extra_i      (s_axis_tdata[73:42]),
    .in_slot_i       (s_axis_tdata[85:74]),
    .in_pred_i       (s_axis_tdata[95:86]),
    .in_link_i       (s_axis_tdata[107:96]),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_status_o    (m_axis_tuser),
    .out_item_o      (out_item),
    .out_value_o     (out_value),
    .out_has_cause_o (out_has_cause),
    .out_cause_o     (out_cause)
  );

  assign s_axis_tready = cmd.take;
  assign m_axis_tdata  = {1'b0, out_cause, out_has_cause, out_value, out_item};

endmodule

// ===== sv/dlpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// DAG longest-path propagator controller
// Sequences host commands and the node and slot walk of a run.
// ----------------------------------------------------------------------------
module dlpp_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [dlpp_pkg::CMD_W-1:0]    in_cmd_i,
  input  dlpp_pkg::dp_status_t          status_i,
  output dlpp_pkg::ctrl_cmd_t           cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_HOST_WAIT, S_N_FETCH, S_N_INIT, S_S_CHECK, S_S_EVAL, S_S_NEXT,
    S_N_WRITE, S_R_DONE
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  assign acc = (state_q == S_IDLE) && status_i.out_free && in_valid_i;

  always_comb begin
    cmd_o      = '0;
    cmd_o.take = (state_q == S_IDLE) && status_i.out_free;
    state_d    = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (in_cmd_i == dlpp_pkg::CMD_RUN) begin
            cmd_o.run_start = 1'b1;
            state_d = S_N_FETCH;
          end else if (in_cmd_i == dlpp_pkg::CMD_READ_NODE ||
                       in_cmd_i == dlpp_pkg::CMD_READ_LINK) begin
            state_d = S_HOST_WAIT;
          end
        end
      end
      S_HOST_WAIT: begin
        cmd_o.out_host = 1'b1;
        state_d = S_IDLE;
      end
      S_N_FETCH: begin
        cmd_o.node_fetch = 1'b1;
        state_d = S_N_INIT;
      end
      S_N_INIT: begin
        cmd_o.node_init = 1'b1;
        if (status_i.node_active && status_i.slots_left) begin
          cmd_o.slot_fetch = 1'b1;
          state_d = S_S_CHECK;
        end else begin
          state_d = S_N_WRITE;
        end
      end
      S_S_CHECK: begin
        // Slots belong to later nodes end this node; stray earlier ones are dropped.
        if (status_i.tgt_gt) begin
          state_d = S_N_WRITE;
        end else if (status_i.tgt_lt) begin
          cmd_o.slot_skip = 1'b1;
          state_d = S_S_NEXT;
        end else begin
          cmd_o.pred_fetch = 1'b1;
          state_d = S_S_EVAL;
        end
      end
      S_S_EVAL: begin
        cmd_o.slot_eval = 1'b1;
        state_d = S_S_NEXT;
      end
      S_S_NEXT: begin
        if (status_i.slots_left) begin
          cmd_o.slot_fetch = 1'b1;
          state_d = S_S_CHECK;
        end else begin
          state_d = S_N_WRITE;
        end
      end
      S_N_WRITE: begin
        cmd_o.node_write = 1'b1;
        state_d = status_i.node_last ? S_R_DONE : S_N_FETCH;
      end
      S_R_DONE: begin
        cmd_o.out_run = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/dlpp_datapath.sv =====
// ----------------------------------------------------------------------------
// DAG longest-path propagator datapath
// Node, link and slot memories, run cursors, best-time tracking and the
// output register.
// ----------------------------------------------------------------------------
module dlpp_datapath #(
  parameter int unsigned MAX_NODES = dlpp_pkg::DEF_MAX_NODES,
  parameter int unsigned MAX_LINKS = dlpp_pkg::DEF_MAX_LINKS,
  parameter int unsigned MAX_SLOTS = dlpp_pkg::DEF_MAX_SLOTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dlpp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dlpp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  input  logic [dlpp_pkg::CMD_W-1:0]       in_cmd_i,
  input  logic [dlpp_pkg::NODE_W-1:0]      in_node_i,
  input  logic signed [dlpp_pkg::TIME_W-1:0] in_time_i,
  input  logic signed [dlpp_pkg::TIME_W-1:0] in_extra_i,
  input  logic [dlpp_pkg::SLOT_W-1:0]      in_slot_i,
  input  logic [dlpp_pkg::NODE_W-1:0]      in_pred_i,
  input  logic [dlpp_pkg::LINK_W-1:0]      in_link_i,
  input  dlpp_pkg::ctrl_cmd_t              cmd_i,
  output dlpp_pkg::dp_status_t             status_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [dlpp_pkg::STATUS_W-1:0]    out_status_o,
  output logic [dlpp_pkg::ITEM_W-1:0]      out_item_o,
  output logic signed [dlpp_pkg::TIME_W-1:0] out_value_o,
  output logic                             out_has_cause_o,
  output logic [dlpp_pkg::NODE_W-1:0]      out_cause_o
);

  localparam int unsigned NA = $clog2(MAX_NODES);
  localparam int unsigned LA = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int unsigned SA = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned SCW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CW = dlpp_pkg::CMP_W;
  localparam int unsigned TW = dlpp_pkg::TIME_W;
  localparam int unsigned NW = dlpp_pkg::NODE_W;
  localparam int unsigned LW = dlpp_pkg::LINK_W;
  localparam logic [CW-1:0] NODE_LIM = CW'(MAX_NODES);
  localparam logic [CW-1:0] LINK_LIM = CW'(MAX_LINKS);
  localparam logic [CW-1:0] SLOT_LIM = CW'(MAX_SLOTS);
  localparam logic [NA-1:0] NODE_END = NA'(MAX_NODES - 1);
  // Slot word: target, predecessor, link from the top bit down.
  localparam int unsigned SLOT_WORD_W = 2 * NW + LW;

  // Signed add that clamps to the time range.
  function automatic logic signed [TW-1:0] sat_add(input logic signed [TW-1:0] a,
                                                   input logic signed [TW-1:0] b);
    logic signed [TW:0] s;
    s = {a[TW-1], a} + {b[TW-1], b};
    if (s[TW] != s[TW-1]) begin
      sat_add = s[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
    end else begin
      sat_add = s[TW-1:0];
    end
  endfunction

  logic [10:0] node_count_q;
  logic [12:0] link_count_q;
  logic [12:0] slot_count_q;

  logic signed [TW-1:0] earliest_mem [MAX_NODES];
  logic signed [TW-1:0] realized_mem [MAX_NODES];
  logic [NW:0]          cause_mem    [MAX_NODES];
  logic signed [TW-1:0] link_mem     [MAX_LINKS];
  logic [SLOT_WORD_W-1:0] slot_mem   [MAX_SLOTS];

  logic                 acc;
  logic                 node_ok, link_ok, slot_ok;
  logic [NA-1:0]        node_cur_q;
  logic [SCW-1:0]       slot_cur_q;
  logic signed [TW-1:0] best_time_q;
  logic [NW-1:0]        best_pred_q;
  logic                 won_q;
  logic [SLOT_WORD_W-1:0] slot_q;
  logic signed [TW-1:0] own_q, pred_e_q, pred_r_q, dur_q;
  logic [NW:0]          cause_q;
  logic                 pred_ok_q, pred_done_q, link_use_q;
  logic [NW-1:0]        pred_q;
  logic [dlpp_pkg::CMD_W-1:0] host_cmd_q;
  logic [NW-1:0]        host_node_q;
  logic [LW-1:0]        host_link_q;
  logic                 host_node_ok_q, host_link_ok_q;
  logic                 out_valid_q;

  logic [NW-1:0]        s_tgt, s_pred;
  logic [LW-1:0]        s_link;
  logic [NA-1:0]        rd_node_addr;
  logic [LA-1:0]        rd_link_addr;
  logic signed [TW-1:0] pt, dur, cand, link_val;

  assign acc     = cmd_i.take && in_valid_i;
  assign node_ok = CW'(in_node_i) < NODE_LIM;
  assign link_ok = CW'(in_link_i) < LINK_LIM;
  assign slot_ok = CW'(in_slot_i) < SLOT_LIM;

  assign s_tgt  = slot_q[SLOT_WORD_W-1 -: NW];
  assign s_pred = slot_q[LW +: NW];
  assign s_link = slot_q[LW-1:0];

  assign rd_node_addr = cmd_i.pred_fetch ? NA'(s_pred) : NA'(in_node_i);
  assign rd_link_addr = cmd_i.pred_fetch ? LA'(s_link) : LA'(in_link_i);

  assign link_val = (in_extra_i > 0) ? sat_add(in_time_i, in_extra_i) : in_time_i;

  assign pt   = !pred_ok_q ? '0 : (pred_done_q ? pred_r_q : pred_e_q);
  assign dur  = link_use_q ? dur_q : '0;
  assign cand = sat_add(pt, dur);

  // Status towards the controller.
  assign status_o.out_free    = !out_valid_q || out_ready_i;
  assign status_o.node_active = CW'(node_cur_q) < CW'(node_count_q);
  assign status_o.node_last   = node_cur_q == NODE_END;
  assign status_o.slots_left  = (CW'(slot_cur_q) < CW'(slot_count_q)) &&
                                (CW'(slot_cur_q) < SLOT_LIM);
  assign status_o.tgt_gt      = CW'(s_tgt) > CW'(node_cur_q);
  assign status_o.tgt_lt      = CW'(s_tgt) < CW'(node_cur_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 11'd1;
      link_count_q <= '0;
      slot_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dlpp_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data_i[10:0];
        dlpp_pkg::CFG_LINK_COUNT: link_count_q <= cfg_data_i;
        dlpp_pkg::CFG_SLOT_COUNT: slot_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Earliest times: host write, own read for the run, predecessor read.
  always_ff @(posedge clk_i) begin
    if (acc && in_cmd_i == dlpp_pkg::CMD_SET_EARLIEST && node_ok) begin
      earliest_mem[NA'(in_node_i)] <= in_time_i;
    end
    if (cmd_i.node_fetch) begin
      own_q <= earliest_mem[node_cur_q];
    end
    if (cmd_i.pred_fetch) begin
      pred_e_q <= earliest_mem[NA'(s_pred)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.node_write) begin
      realized_mem[node_cur_q] <= best_time_q;
    end
    if (cmd_i.pred_fetch || acc) begin
      pred_r_q <= realized_mem[rd_node_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.node_write) begin
      cause_mem[node_cur_q] <= won_q ? {1'b1, best_pred_q} : '0;
    end
    if (acc) begin
      cause_q <= cause_mem[NA'(in_node_i)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && in_cmd_i == dlpp_pkg::CMD_SET_LINK && link_ok) begin
      link_mem[LA'(in_link_i)] <= link_val;
    end
    if (cmd_i.pred_fetch || acc) begin
      dur_q <= link_mem[rd_link_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && in_cmd_i == dlpp_pkg::CMD_SET_SLOT && slot_ok) begin
      slot_mem[SA'(in_slot_i)] <= {in_node_i, in_pred_i, in_link_i};
    end
    if (cmd_i.slot_fetch) begin
      slot_q <= slot_mem[SA'(slot_cur_q)];
    end
  end

  // Run state and host read bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_cur_q  <= '0;
      slot_cur_q  <= '0;
      best_time_q <= '0;
      best_pred_q <= '0;
      won_q       <= 1'b0;
    end else begin
      if (cmd_i.run_start) begin
        node_cur_q <= '0;
        slot_cur_q <= '0;
      end
      if (cmd_i.node_write) begin
        node_cur_q <= node_cur_q + NA'(1);
      end
      if (cmd_i.slot_skip || cmd_i.pred_fetch) begin
        slot_cur_q <= slot_cur_q + SCW'(1);
      end
      if (cmd_i.node_init) begin
        best_time_q <= own_q;
        best_pred_q <= '0;
        won_q       <= 1'b0;
      end
      if (cmd_i.slot_eval && cand > best_time_q) begin
        best_time_q <= cand;
        best_pred_q <= pred_q;
        won_q       <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pred_fetch) begin
      pred_q      <= s_pred;
      pred_ok_q   <= CW'(s_pred) < NODE_LIM;
      pred_done_q <= CW'(s_pred) < CW'(node_cur_q);
      link_use_q  <= (CW'(s_link) < CW'(link_count_q)) && (CW'(s_link) < LINK_LIM);
    end
    if (acc) begin
      host_cmd_q     <= in_cmd_i;
      host_node_q    <= in_node_i;
      host_link_q    <= in_link_i;
      host_node_ok_q <= node_ok;
      host_link_ok_q <= link_ok;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_run || cmd_i.out_host) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_run) begin
      out_status_o    <= dlpp_pkg::ST_RUN_DONE;
      out_item_o      <= '0;
      out_value_o     <= '0;
      out_has_cause_o <= 1'b0;
      out_cause_o     <= '0;
    end else if (cmd_i.out_host) begin
      if (host_cmd_q == dlpp_pkg::CMD_READ_NODE) begin
        out_status_o    <= dlpp_pkg::ST_NODE_READ;
        out_item_o      <= dlpp_pkg::ITEM_W'(host_node_q);
        out_value_o     <= host_node_ok_q ? pred_r_q : '0;
        out_has_cause_o <= host_node_ok_q && cause_q[NW];
        out_cause_o     <= (host_node_ok_q && cause_q[NW]) ? cause_q[NW-1:0] : '0;
      end else begin
        out_status_o    <= dlpp_pkg::ST_LINK_READ;
        out_item_o      <= dlpp_pkg::ITEM_W'(host_link_q);
        out_value_o     <= host_link_ok_q ? dur_q : '0;
        out_has_cause_o <= 1'b0;
        out_cause_o     <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
